[rtl/diag_frame_receiver_macros.svh]
// Assertion macros shared by the diagnostic frame receiver RTL.
// Depends on nothing; the asserting modules provide clk and rst_n.
`ifndef DIAG_FRAME_RECEIVER_MACROS_SVH
`define DIAG_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define DFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfr assertion failed");

// Next-cycle implication, checked out of reset.
`define DFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfr assertion failed");

`else

`define DFR_ASSERT_IMPLY(label, ante, cons)
`define DFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/dfr_pkg.sv]
// Shared types and constants for the diagnostic frame receiver.
// No dependencies.
package dfr_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd3;
  localparam logic [BYTE_W-1:0] SUM_OK        = 8'h00;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // frame status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CSUM    = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  typedef struct packed {
    logic              item_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] frame_header;
    logic [BYTE_W-1:0] frame_length;
    logic [1:0]        frame_status;
    logic              frame_last;
  } dfr_result_t;

endpackage

[rtl/dfr_in_if.sv]
// Valid/ready channel for received bytes.
// Depends on dfr_pkg.
interface dfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [dfr_pkg::BYTE_W-1:0] rx_byte;
  logic                      frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

[rtl/dfr_out_if.sv]
// Valid/ready channel for data byte and frame end results.
// Depends on dfr_pkg.
interface dfr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [dfr_pkg::BYTE_W-1:0] data_byte;
  logic [dfr_pkg::BYTE_W-1:0] byte_index;
  logic [dfr_pkg::BYTE_W-1:0] frame_header;
  logic [dfr_pkg::BYTE_W-1:0] frame_length;
  logic [1:0]                frame_status;
  logic                      frame_last;

  modport source (
    output valid, output item_kind, output data_byte, output byte_index,
    output frame_header, output frame_length, output frame_status,
    output frame_last, input ready
  );
  modport sink (
    input valid, input item_kind, input data_byte, input byte_index,
    input frame_header, input frame_length, input frame_status,
    input frame_last, output ready
  );
endinterface

[rtl/dfr_frame_fsm.sv]
// Frame parser: phase, running sum, held header/length and data index.
// Depends on dfr_pkg and diag_frame_receiver_macros.svh.
`include "diag_frame_receiver_macros.svh"

module dfr_frame_fsm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [dfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       frame_start,
  output logic                       res_valid,
  output dfr_pkg::dfr_result_t       res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [dfr_pkg::BYTE_W-1:0] running_sum_r, running_sum_nxt;
  logic [dfr_pkg::BYTE_W-1:0] held_header_r, held_header_nxt;
  logic [dfr_pkg::BYTE_W-1:0] held_length_r, held_length_nxt;
  logic [dfr_pkg::BYTE_W-1:0] data_position_r, data_position_nxt;

  logic [dfr_pkg::BYTE_W-1:0] sum_add;
  logic [dfr_pkg::BYTE_W-1:0] pos_inc;
  logic [dfr_pkg::BYTE_W-1:0] data_count;

  assign sum_add    = running_sum_r + rx_byte;
  assign pos_inc    = data_position_r + 8'd1;
  assign data_count = held_length_r - dfr_pkg::MIN_FRAME_LEN;

  always_comb begin
    phase_nxt         = phase_r;
    running_sum_nxt   = running_sum_r;
    held_header_nxt   = held_header_r;
    held_length_nxt   = held_length_r;
    data_position_nxt = data_position_r;
    res_valid         = 1'b0;
    res.item_kind     = dfr_pkg::KIND_DATA;
    res.data_byte     = '0;
    res.byte_index    = '0;
    res.frame_header  = held_header_r;
    res.frame_length  = held_length_r;
    res.frame_status  = dfr_pkg::STATUS_OK;
    res.frame_last    = 1'b0;

    if (accept) begin
      priority if (frame_start || phase_r == PH_HEADER) begin
        // new header: any partial frame is dropped without a result
        held_header_nxt   = rx_byte;
        held_length_nxt   = '0;
        running_sum_nxt   = rx_byte;
        data_position_nxt = '0;
        phase_nxt         = PH_LENGTH;
      end else begin
        unique case (phase_r)
          PH_LENGTH: begin
            held_length_nxt   = rx_byte;
            running_sum_nxt   = sum_add;
            data_position_nxt = '0;
            if (rx_byte < dfr_pkg::MIN_FRAME_LEN) begin
              phase_nxt        = PH_HEADER;
              res_valid        = 1'b1;
              res.item_kind    = dfr_pkg::KIND_END;
              res.frame_length = rx_byte;
              res.frame_status = dfr_pkg::STATUS_LEN_ERR;
              res.frame_last   = 1'b1;
            end else if (rx_byte == dfr_pkg::MIN_FRAME_LEN) begin
              phase_nxt = PH_CHECK;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            running_sum_nxt   = sum_add;
            data_position_nxt = pos_inc;
            if (pos_inc >= data_count) begin
              phase_nxt = PH_CHECK;
            end
            res_valid      = 1'b1;
            res.data_byte  = rx_byte;
            res.byte_index = data_position_r;
          end
          PH_CHECK: begin
            running_sum_nxt  = sum_add;
            phase_nxt        = PH_HEADER;
            res_valid        = 1'b1;
            res.item_kind    = dfr_pkg::KIND_END;
            res.frame_status = (sum_add == dfr_pkg::SUM_OK) ? dfr_pkg::STATUS_OK
                                                            : dfr_pkg::STATUS_CSUM;
            res.frame_last   = 1'b1;
          end
          PH_HEADER: begin
            // handled above
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      running_sum_r   <= '0;
      held_header_r   <= '0;
      held_length_r   <= '0;
      data_position_r <= '0;
    end else begin
      phase_r         <= phase_nxt;
      running_sum_r   <= running_sum_nxt;
      held_header_r   <= held_header_nxt;
      held_length_r   <= held_length_nxt;
      data_position_r <= data_position_nxt;
    end
  end

  // data phase is only entered for frames that carry payload
  `DFR_ASSERT_IMPLY(a_data_len, phase_r == PH_DATA, held_length_r > dfr_pkg::MIN_FRAME_LEN)
  // index never runs past the payload size
  `DFR_ASSERT_IMPLY(a_data_pos, phase_r == PH_DATA, data_position_r < data_count)

endmodule

[rtl/dfr_out_buf.sv]
// Two-entry output buffer (result register plus skid) for result beats.
// Depends on dfr_pkg, dfr_out_if and diag_frame_receiver_macros.svh.
`include "diag_frame_receiver_macros.svh"

module dfr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dfr_pkg::dfr_result_t push_data,
  output logic                 in_ready,
  dfr_out_if.source            out_bus
);

  dfr_pkg::dfr_result_t main_r;
  dfr_pkg::dfr_result_t skid_r;
  logic                 main_valid_r;
  logic                 skid_valid_r;
  logic                 pop;

  assign pop      = main_valid_r && out_bus.ready;
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!main_valid_r || pop) begin
        if (skid_valid_r) begin
          main_r       <= skid_r;
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          main_r       <= push_data;
          main_valid_r <= push;
        end
      end else if (push) begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_bus.valid        = main_valid_r;
  assign out_bus.item_kind    = main_r.item_kind;
  assign out_bus.data_byte    = main_r.data_byte;
  assign out_bus.byte_index   = main_r.byte_index;
  assign out_bus.frame_header = main_r.frame_header;
  assign out_bus.frame_length = main_r.frame_length;
  assign out_bus.frame_status = main_r.frame_status;
  assign out_bus.frame_last   = main_r.frame_last;

  // skid only fills behind an occupied result register
  `DFR_ASSERT_IMPLY(a_skid_order, skid_valid_r, main_valid_r)
  // a beat is never pushed into a full buffer
  `DFR_ASSERT_IMPLY(a_no_overflow, push, !skid_valid_r)

endmodule

[rtl/diag_frame_receiver.sv]
// Top level of the diagnostic frame receiver: frame parser plus output buffer.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if, dfr_frame_fsm, dfr_out_buf.
//
// channel  | dir | payload                                          | handshake
// ---------+-----+--------------------------------------------------+----------
// in_bus   | in  | rx_byte, frame_start                             | valid/ready
// out_bus  | out | item_kind, data_byte, byte_index, frame_header,  | valid/ready
//          |     | frame_length, frame_status, frame_last           |
//
// One byte per cycle while in_bus.ready is high: the parser updates its state
// in the cycle a beat is accepted, and the result is registered into the result
// register, or into the skid entry while the result register is stalled.
// in_bus.ready is registered; it drops only when both the result register
// and the skid entry hold beats, i.e. once a second result beat arrives
// while the first one is still stalled on out_bus.
// A header byte and a length byte of 3 or more make no result; every other
// byte makes exactly one.
// rst_n is synchronous, active low; the parser returns to expecting a header.
module diag_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  dfr_in_if.sink     in_bus,
  dfr_out_if.source  out_bus
);

  logic                 in_accept;
  logic                 buf_ready;
  logic                 res_valid;
  dfr_pkg::dfr_result_t res;

  assign in_bus.ready = buf_ready;
  assign in_accept    = in_bus.valid && buf_ready;

  dfr_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_bus.rx_byte),
    .frame_start (in_bus.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  dfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (buf_ready),
    .out_bus   (out_bus)
  );

endmodule

[tb/tb_top.sv]
// Self-checking bench for diag_frame_receiver: byte beats in, data and frame end
// results out, each result checked against a frame parser kept in the bench.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if and the receiver RTL.
module tb_top;

  // Cycles with no handshake on either channel before the run is called
  // hung. The longest quiet stretch is the receiver hold-off plus one
  // per-beat stall, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TARGET_BEATS = 1050;
  localparam int TAIL_CYCLES = 8;

  // Parser phases, mirrored from what the block has to track.
  typedef enum logic [1:0] {
    WAIT_HEADER,
    WAIT_LENGTH,
    WAIT_DATA,
    WAIT_CHECK
  } rx_phase_t;

  logic clk;
  logic rst_n;

  dfr_in_if  in_bus ();
  dfr_out_if out_bus ();

  diag_frame_receiver DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #5 clk = ~clk;

  // Bench copy of the parser state.
  rx_phase_t  phase_q;
  logic [7:0] sum_q;
  logic [7:0] header_q;
  logic [7:0] length_q;
  logic [7:0] pos_q;

  dfr_pkg::dfr_result_t owed_results[$];

  int  errors;
  int  beats_sent;
  bit  idle_in;      // sender draws gaps between beats
  bit  idle_out;     // receiver draws stalls between beats
  int  stall_left;   // receiver stall cycles still to wait
  int  hold_cycles;  // long receiver hold-off, counted down by the receiver
  int  quiet_cycles;

  // Advance the parser by one accepted byte and queue whatever it owes.
  task automatic parse_byte(input logic [7:0] b, input logic st);
    dfr_pkg::dfr_result_t r;
    r = '0;
    if (st || phase_q == WAIT_HEADER) begin
      // A start flag drops any partial frame with no result.
      header_q = b;
      length_q = 8'd0;
      sum_q    = b;
      pos_q    = 8'd0;
      phase_q  = WAIT_LENGTH;
    end else if (phase_q == WAIT_LENGTH) begin
      length_q = b;
      sum_q    = sum_q + b;
      pos_q    = 8'd0;
      if (b < dfr_pkg::MIN_FRAME_LEN) begin
        phase_q        = WAIT_HEADER;
        r.item_kind    = dfr_pkg::KIND_END;
        r.frame_header = header_q;
        r.frame_length = length_q;
        r.frame_status = dfr_pkg::STATUS_LEN_ERR;
        r.frame_last   = 1'b1;
        owed_results.push_back(r);
      end else begin
        phase_q = (b == dfr_pkg::MIN_FRAME_LEN) ? WAIT_CHECK : WAIT_DATA;
      end
    end else if (phase_q == WAIT_DATA) begin
      r.item_kind    = dfr_pkg::KIND_DATA;
      r.data_byte    = b;
      r.byte_index   = pos_q;
      r.frame_header = header_q;
      r.frame_length = length_q;
      sum_q = sum_q + b;
      pos_q = pos_q + 8'd1;
      if (pos_q >= length_q - dfr_pkg::MIN_FRAME_LEN) phase_q = WAIT_CHECK;
      owed_results.push_back(r);
    end else begin
      sum_q          = sum_q + b;
      phase_q        = WAIT_HEADER;
      r.item_kind    = dfr_pkg::KIND_END;
      r.frame_header = header_q;
      r.frame_length = length_q;
      r.frame_status = (sum_q == dfr_pkg::SUM_OK) ? dfr_pkg::STATUS_OK
                                                  : dfr_pkg::STATUS_CSUM;
      r.frame_last   = 1'b1;
      owed_results.push_back(r);
    end
  endtask

  // Send one byte beat. Called and returns at a falling edge; valid stays
  // high on return so back-to-back beats need no extra edge.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = idle_in ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.rx_byte     = b;
    in_bus.frame_start = st;
    do @(posedge clk); while (!in_bus.ready);
    parse_byte(b, st);
    beats_sent++;
    @(negedge clk);
  endtask

  // Whole frame with random payload. A truncated frame stops after a random
  // share of the data, possibly all of it, and never sends its checksum.
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len,
                            input logic st, input bit good_sum, input bit trunc);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    sum = hdr + len;
    send_byte(hdr, st);
    send_byte(len, 1'b0);
    if (len < dfr_pkg::MIN_FRAME_LEN) return;
    n = int'(len) - int'(dfr_pkg::MIN_FRAME_LEN);
    if (trunc) n = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b, 1'b0);
    end
    if (trunc) return;
    b = 8'd0 - sum;
    if (!good_sum) b = b + 8'($urandom_range(1, 255));
    send_byte(b, 1'b0);
  endtask

  // Stop offering and wait for every owed result.
  task automatic drain_results();
    in_bus.valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Extremes, all three statuses, minimum length, start flag in each phase.
  task automatic test_directed();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_byte(8'h00, 1'b0);  // header taken while idle
    send_byte(8'h00, 1'b0);  // length 0 -> length error
    send_byte(8'hFF, 1'b1);  // start on a header that is expected anyway
    send_byte(8'h01, 1'b0);  // length 1 -> length error
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b0);  // minimum length, no data
    send_byte(8'hFC, 1'b0);  // checksum good
    send_byte(8'hFF, 1'b1);
    send_byte(8'h04, 1'b0);  // one data byte at index 0
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);  // checksum bad
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b1);  // start while length expected: restart
    send_byte(8'h03, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h33, 1'b1);  // start mid data: partial frame dropped
    send_byte(8'h03, 1'b0);
    send_byte(8'hCA, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h41, 1'b1);  // start where checksum expected
    send_byte(8'h02, 1'b0);  // length 2 -> length error
  endtask

  // Longest frame: indices run up to 251.
  task automatic test_max_length();
    idle_in  = 1'b0;
    idle_out = 1'b1;
    send_frame(8'hA5, 8'd255, 1'b1, 1'b1, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering, so the output buffer
  // fills and in_bus.ready drops.
  task automatic test_backpressure();
    idle_in     = 1'b0;
    idle_out    = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    send_frame(8'h5C, 8'd40, 1'b1, 1'b1, 1'b0);
    send_frame(8'hC3, 8'd6, 1'b1, 1'b0, 1'b0);
  endtask

  // Sender pauses mid frame until nothing is owed, then finishes the frame.
  task automatic test_drain_pause();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_byte(8'h7E, 1'b1);
    send_byte(8'h07, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    drain_results();
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h8B, 1'b0);  // closes the frame with a bad checksum
    drain_results();
  endtask

  // Mostly well-formed frames with random content; the rest is truncated
  // frames followed by a restart, and bursts of raw noise.
  task automatic test_random();
    int         pick;
    int         len_sel;
    logic [7:0] len;
    bit         restart;
    restart = 1'b0;
    while (beats_sent < TARGET_BEATS) begin
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      pick     = $urandom_range(0, 99);
      len_sel  = $urandom_range(0, 59);
      if (len_sel == 0)     len = 8'($urandom_range(128, 255));
      else if (len_sel < 5) len = 8'($urandom_range(0, 2));
      else                  len = 8'($urandom_range(3, 16));
      if (pick < 70) begin
        send_frame(8'($urandom_range(0, 255)), len,
                   restart | 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0), 1'b0);
        restart = 1'b0;
      end else if (pick < 82) begin
        send_frame(8'($urandom_range(0, 255)), len, restart | 1'($urandom_range(0, 1)),
                   1'b1, 1'b1);
        restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        restart = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Drives out_bus.ready at the falling edge: the long hold-off wins, then
  // the per-beat stall drawn by the checker, otherwise ready.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Each result beat is matched against the oldest owed result.
  always @(posedge clk) begin
    dfr_pkg::dfr_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing owed: kind %0d header %0d",
               out_bus.item_kind, out_bus.frame_header);
        errors++;
      end else begin
        exp_r = owed_results.pop_front();
        check_field("item_kind", 8'(exp_r.item_kind), 8'(out_bus.item_kind));
        check_field("data_byte", exp_r.data_byte, out_bus.data_byte);
        check_field("byte_index", exp_r.byte_index, out_bus.byte_index);
        check_field("frame_header", exp_r.frame_header, out_bus.frame_header);
        check_field("frame_length", exp_r.frame_length, out_bus.frame_length);
        check_field("frame_status", 8'(exp_r.frame_status), 8'(out_bus.frame_status));
        check_field("frame_last", 8'(exp_r.frame_last), 8'(out_bus.frame_last));
      end
      stall_left = idle_out ? $urandom_range(0, 11) : 0;
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.rx_byte     = 8'h00;
    in_bus.frame_start = 1'b0;
    errors             = 0;
    beats_sent         = 0;
    idle_in            = 1'b0;
    idle_out           = 1'b0;
    stall_left         = 0;
    hold_cycles        = 0;
    quiet_cycles       = 0;
    phase_q            = WAIT_HEADER;
    sum_q              = 8'h00;
    header_q           = 8'h00;
    length_q           = 8'h00;
    pos_q              = 8'h00;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_max_length();
    test_backpressure();
    test_drain_pause();
    test_random();

    // All beats are in; let every owed result arrive, then keep watching
    // out_bus for anything extra.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dfr_pkg.sv
rtl/dfr_in_if.sv
rtl/dfr_out_if.sv
rtl/dfr_frame_fsm.sv
rtl/dfr_out_buf.sv
rtl/diag_frame_receiver.sv
tb/tb_top.sv
